// ----- rtl/psd_pkg.sv -----
// Shared types and constants for the polarization Stokes demosaic block.
package psd_pkg;

   localparam int unsigned PitchWidth  = 14;
   localparam int unsigned WidthWidth  = 11;
   localparam int unsigned HeightWidth = 13;
   localparam int unsigned HeightCap   = 4096;
   localparam int unsigned CountWidth  = 13;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LINE_PITCH = 2'd0;
   localparam logic [1:0] CSR_OUT_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_OUT_HEIGHT = 2'd2;

   // One classified superpixel handed from the front part to the back part.
   typedef struct packed {
      logic [7:0] i0;
      logic [7:0] i45;
      logic [7:0] i90;
      logic [7:0] i135;
      logic       last;
   } pix_type;

   // Result of the back part.
   typedef struct packed {
      logic [7:0] i0;
      logic [7:0] i45;
      logic [7:0] i90;
      logic [7:0] i135;
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] s2;
      logic [7:0] dolp;
      logic       last;
   } res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DIV,
      ST_DONE
   } back_state_type;

endpackage

// ----- rtl/psd_front.sv -----
// Front part: counts the raster, keeps the even row and forms superpixels.
module psd_front #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_PITCH = 8192
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [7:0]                        in_byte,
   input  logic [psd_pkg::PitchWidth-1:0]    pitch_reg,
   input  logic [psd_pkg::WidthWidth-1:0]    width_reg,
   input  logic [psd_pkg::HeightWidth-1:0]   height_reg,
   output logic                              pix_valid,
   input  logic                              pix_ready,
   output psd_pkg::pix_type                  pix
);
   localparam int unsigned Depth = 2 * MAX_WIDTH;
   localparam int unsigned AddrW = $clog2(Depth);
   localparam int unsigned CW    = psd_pkg::CountWidth + 2;

   logic [7:0] line_mem [Depth];

   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [7:0]    held_ff, held_in;
   logic [CW-1:0] pitch_eff, half_lim, width_eff, rows_eff;
   logic [CW-1:0] h_clamp;
   logic          accept, active, even_row, odd_col, emit;

   // Stage between the pixel read and the hand-off to the queue.
   logic             stg_valid_ff, stg_valid_in;
   logic [7:0]       stg_i0_ff, stg_i135_ff;
   logic             stg_last_ff;
   logic [7:0]       rd90_ff, rd45_ff;

   always_comb begin
      pitch_eff = CW'(pitch_reg);
      if (pitch_eff < CW'(2)) pitch_eff = CW'(2);
      if (pitch_eff > CW'(MAX_PITCH)) pitch_eff = CW'(MAX_PITCH);
      half_lim = pitch_eff >> 1;
      if (half_lim > CW'(MAX_WIDTH)) half_lim = CW'(MAX_WIDTH);
      width_eff = CW'(width_reg);
      if (width_eff > half_lim) width_eff = half_lim;
      if (width_eff < CW'(1)) width_eff = CW'(1);
      h_clamp = CW'(height_reg);
      if (h_clamp > CW'(psd_pkg::HeightCap)) h_clamp = CW'(psd_pkg::HeightCap);
      if (h_clamp < CW'(1)) h_clamp = CW'(1);
      rows_eff = h_clamp << 1;
   end

   // The stage holds at most one superpixel; it drains into the queue.
   assign in_ready = !stg_valid_ff || pix_ready;
   assign accept   = in_valid && in_ready;
   assign active   = (row_ff < rows_eff) && (col_ff < (width_eff << 1));
   assign even_row = !row_ff[0];
   assign odd_col  = col_ff[0];
   assign emit     = accept && active && !even_row && odd_col;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (accept) begin
         if (active && !even_row && !odd_col) held_in = in_byte;
         col_in = col_ff + CW'(1);
         if (col_in >= pitch_eff) begin
            col_in = '0;
            row_in = row_ff + CW'(1);
            if (row_in >= rows_eff) row_in = '0;
         end
      end
      stg_valid_in = emit || (stg_valid_ff && !pix_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         held_ff      <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_ff      <= held_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   // Line store: written on even rows, read as a 90/45 pair on odd columns.
   always_ff @(posedge clock) begin
      if (accept && active && even_row) begin
         line_mem[col_ff[AddrW-1:0]] <= in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rd45_ff     <= line_mem[col_ff[AddrW-1:0]];
         rd90_ff     <= line_mem[col_ff[AddrW-1:0] - AddrW'(1)];
         stg_i0_ff   <= in_byte;
         stg_i135_ff <= held_ff;
         stg_last_ff <= (row_ff == rows_eff - CW'(1)) &&
                        ((col_ff >> 1) == width_eff - CW'(1));
      end
   end

   assign pix_valid = stg_valid_ff;
   assign pix.i0    = stg_i0_ff;
   assign pix.i45   = rd45_ff;
   assign pix.i90   = rd90_ff;
   assign pix.i135  = stg_i135_ff;
   assign pix.last  = stg_last_ff;

`ifndef SYNTHESIS
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= CW'(2 * psd_pkg::HeightCap))
      else $error("row counter out of range");
   a_emit_odd: assert property (@(posedge clock) disable iff (reset)
      emit |-> row_ff[0] && col_ff[0])
      else $error("superpixel emitted off the 0 degree position");
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !pix_ready |=> stg_valid_ff && $stable(stg_i0_ff))
      else $error("stalled superpixel changed");
`endif
endmodule

// ----- rtl/psd_queue.sv -----
// Short queue between the front and back parts.
module psd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  psd_pkg::pix_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output psd_pkg::pix_type rd_data
);
   psd_pkg::pix_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = cnt_ff != 3'd4;
   assign rd_valid = cnt_ff != 3'd0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 3'd1;
      if (pop && !push) cnt_in = cnt_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("queue count overflow");
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'd4 && !pop |=> cnt_ff == 3'd4)
      else $error("full queue lost an entry");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 3'd0 || cnt_ff == 3'd4) |-> wp_ff == rp_ff)
      else $error("queue pointers disagree with count");
`endif
endmodule

// ----- rtl/psd_back.sv -----
// Back part: Stokes terms, iterative square root and divider for DoLP.
module psd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pix_valid,
   output logic             pix_ready,
   input  psd_pkg::pix_type pix,
   output logic             res_valid,
   input  logic             res_ready,
   output psd_pkg::res_type res
);
   psd_pkg::back_state_type st_ff, st_in;

   psd_pkg::pix_type cur_ff;
   logic [7:0]  s0_ff, s1_ff, s2_ff;
   logic [33:0] rem_ff, rem_in;     // square root remainder
   logic [16:0] root_ff, root_in;
   logic [4:0]  step_ff, step_in;
   logic [16:0] num_ff, num_in;     // divider remainder
   logic [16:0] quo_ff, quo_in;
   logic        load, load_root, load_div;

   logic [8:0]  d1a, d2a;
   logic [17:0] sq;
   logic [9:0]  sum4;
   logic [7:0]  s0_c, den;
   logic [8:0]  h1, h2;

   assign pix_ready = (st_ff == psd_pkg::ST_IDLE);
   assign load      = pix_valid && pix_ready;

   always_comb begin
      sum4 = 10'(pix.i0) + 10'(pix.i45) + 10'(pix.i90) + 10'(pix.i135);
      s0_c = sum4[9] ? 8'd255 : sum4[8:1];
      h1   = 9'((10'(pix.i0) + 10'd256 - 10'(pix.i90)) >> 1);
      h2   = 9'((10'(pix.i45) + 10'd256 - 10'(pix.i135)) >> 1);
      d1a  = pix.i0 >= pix.i90 ? 9'(pix.i0 - pix.i90) : 9'(pix.i90 - pix.i0);
      d2a  = pix.i45 >= pix.i135 ? 9'(pix.i45 - pix.i135) : 9'(pix.i135 - pix.i45);
      sq   = (18'(d1a) * 18'(d1a)) + (18'(d2a) * 18'(d2a));
      den  = s0_ff == 8'd0 ? 8'd1 : s0_ff;
   end

   // Square root works two radicand bits per cycle, the divider one bit.
   logic [35:0] rad_ff;
   logic [35:0] rad_in;
   logic [18:0] rt_try;
   logic [18:0] rrem;

   always_comb begin
      st_in   = st_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rad_in  = rad_ff;
      rrem    = '0;
      rt_try  = '0;
      load_root = 1'b0;
      load_div  = 1'b0;
      case (st_ff)
         psd_pkg::ST_IDLE: begin
            if (load) begin
               load_root = 1'b1;
               st_in   = psd_pkg::ST_ROOT;
               rad_in  = 36'(sq) * 36'd65025;
               rem_in  = '0;
               root_in = '0;
               step_in = 5'd17;
            end
         end
         psd_pkg::ST_ROOT: begin
            rrem   = {rem_ff[16:0], rad_ff[35:34]};
            rt_try = {root_ff, 2'b01};
            if (rrem >= rt_try) begin
               rem_in  = 34'(rrem - rt_try);
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = 34'(rrem);
               root_in = {root_ff[15:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               load_div = 1'b1;
               st_in    = psd_pkg::ST_DIV;
               num_in   = '0;
               quo_in   = '0;
               step_in  = 5'd17;
            end
         end
         psd_pkg::ST_DIV: begin
            // Root bits are shifted out of root_ff from the top.
            if ({num_ff[15:0], root_ff[16]} >= 17'(den)) begin
               num_in = {num_ff[15:0], root_ff[16]} - 17'(den);
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               num_in = {num_ff[15:0], root_ff[16]};
               quo_in = {quo_ff[15:0], 1'b0};
            end
            root_in = root_ff << 1;
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd1) st_in = psd_pkg::ST_DONE;
         end
         psd_pkg::ST_DONE: begin
            if (!res_valid || res_ready) st_in = psd_pkg::ST_IDLE;
         end
         default: st_in = psd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= psd_pkg::ST_IDLE;
      else       st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rad_ff  <= rad_in;
      if (load) begin
         cur_ff <= pix;
         s0_ff  <= s0_c;
         s1_ff  <= h1[8] ? 8'd255 : h1[7:0];
         s2_ff  <= h2[8] ? 8'd255 : h2[7:0];
      end
   end

   // Output register; the next item computes while a result waits.
   logic        out_valid_ff;
   psd_pkg::res_type out_ff;
   logic        fin;
   assign fin = (st_ff == psd_pkg::ST_DONE) && (!out_valid_ff || res_ready);

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (fin) out_valid_ff <= 1'b1;
      else if (res_ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         out_ff.i0   <= cur_ff.i0;
         out_ff.i45  <= cur_ff.i45;
         out_ff.i90  <= cur_ff.i90;
         out_ff.i135 <= cur_ff.i135;
         out_ff.s0   <= s0_ff;
         out_ff.s1   <= s1_ff;
         out_ff.s2   <= s2_ff;
         out_ff.dolp <= quo_ff > 17'd255 ? 8'd255 : quo_ff[7:0];
         out_ff.last <= cur_ff.last;
      end
   end

   assign res_valid = out_valid_ff;
   assign res       = out_ff;

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      load |=> st_ff == psd_pkg::ST_ROOT)
      else $error("accepted superpixel did not start the root");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      load_div |=> st_ff == psd_pkg::ST_DIV && num_ff == '0)
      else $error("divider not cleared at start");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(out_ff))
      else $error("stalled result changed");
   a_root_start: assert property (@(posedge clock) disable iff (reset)
      load_root |=> step_ff == 5'd17 && root_ff == '0)
      else $error("square root not cleared at start");
`endif
endmodule

// ----- rtl/polarization_stokes_demosaic.sv -----
// Top level of the polarization Stokes demosaic block.
// Usage:
//   csr_*: write line_pitch (index 0), out_width (1) and out_height (2) while
//   the block is idle. The channel is always ready.
//   req_*: raw mosaic bytes, row by row. The front part takes one byte per
//   cycle while its output stage and the four-entry queue have room.
//   rsp_*: one result per 2x2 superpixel, on the 0 degree byte, with the four
//   intensities, S0, S1, S2, DoLP and a frame end flag.
// Processing:
//   The back part takes each superpixel through a load step, 18
//   steps of a two-bit-per-cycle square root, 17 steps of a one-bit-per-cycle
//   divider and a write into the output register. Even rows carry no
//   superpixels and go at one byte per cycle while req_ready is high;
//   on odd rows the pace is set by the back part, which takes a new
//   superpixel only once the last one has reached the output register.
// Reset clears counters, held pixel, queue and handshakes; the registers
//   return to 2048, 1024 and 1024. The line store is not cleared.
// A stalled receiver holds the result register; the back part then stops,
//   the queue fills and req_ready drops.
module polarization_stokes_demosaic #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_PITCH = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_raw_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_intensity_0,
   output logic [7:0]  rsp_intensity_45,
   output logic [7:0]  rsp_intensity_90,
   output logic [7:0]  rsp_intensity_135,
   output logic [7:0]  rsp_s0_value,
   output logic [7:0]  rsp_s1_value,
   output logic [7:0]  rsp_s2_value,
   output logic [7:0]  rsp_dolp,
   output logic        rsp_frame_last
);
   logic [psd_pkg::PitchWidth-1:0]  pitch_ff;
   logic [psd_pkg::WidthWidth-1:0]  width_ff;
   logic [psd_pkg::HeightWidth-1:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff  <= 14'd2048;
         width_ff  <= 11'd1024;
         height_ff <= 13'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            psd_pkg::CSR_LINE_PITCH: pitch_ff  <= csr_data;
            psd_pkg::CSR_OUT_WIDTH:  width_ff  <= csr_data[10:0];
            psd_pkg::CSR_OUT_HEIGHT: height_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   logic             f_valid, f_ready, q_valid, q_ready;
   psd_pkg::pix_type f_pix, q_pix;
   psd_pkg::res_type r;

   psd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_PITCH(MAX_PITCH)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_byte(req_raw_byte),
      .pitch_reg(pitch_ff), .width_reg(width_ff), .height_reg(height_ff),
      .pix_valid(f_valid), .pix_ready(f_ready), .pix(f_pix)
   );

   psd_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_pix),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_pix)
   );

   psd_back u_back (
      .clock, .reset,
      .pix_valid(q_valid), .pix_ready(q_ready), .pix(q_pix),
      .res_valid(rsp_valid), .res_ready(rsp_ready), .res(r)
   );

   assign rsp_intensity_0   = r.i0;
   assign rsp_intensity_45  = r.i45;
   assign rsp_intensity_90  = r.i90;
   assign rsp_intensity_135 = r.i135;
   assign rsp_s0_value      = r.s0;
   assign rsp_s1_value      = r.s1;
   assign rsp_s2_value      = r.s2;
   assign rsp_dolp          = r.dolp;
   assign rsp_frame_last    = r.last;
endmodule
